/* rtl/core/pts_pkg.sv */
// shared types, event codes and control store of the task scheduler
`default_nettype none
package pts_pkg;

   localparam int TASK_SLOTS_DEFAULT = 8;
   localparam int PRIO_W  = 8;
   localparam int DELAY_W = 32;
   localparam int TICK_W  = 32;
   localparam int TASK_W  = 3;

   localparam logic [1:0] FUNC_CREATE   = 2'd0;
   localparam logic [1:0] FUNC_DELAY    = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;
   localparam logic [1:0] FUNC_SCHEDULE = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [PRIO_W-1:0]  new_priority;
      logic [DELAY_W-1:0] delay_amount;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0] running_task;
      logic              running_valid;
      logic              accepted;
      logic [TICK_W-1:0] tick_total;
   } rsp_type;

   typedef struct packed {
      logic               blocked;
      logic [DELAY_W-1:0] delay;
   } slot_state_type;

   localparam int STATE_W = $bits(slot_state_type);

   typedef enum logic [2:0] {
      STEP_CREATE     = 3'd0,
      STEP_DELAY      = 3'd1,
      STEP_TICK       = 3'd2,
      STEP_SCAN_START = 3'd3,
      STEP_SCAN       = 3'd4,
      STEP_COMMIT     = 3'd5,
      STEP_DONE       = 3'd6
   } step_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_IF_EMPTY,
      JMP_IF_MORE
   } jump_type;

   typedef struct packed {
      logic     wr_create;
      logic     wr_delay;
      logic     tick_inc;
      logic     scan_start;
      logic     scan_step;
      logic     commit;
      logic     done;
      jump_type jump;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic more;
   } status_type;

   localparam ctrl_type CTRL_NOP = '{
      wr_create: 1'b0, wr_delay: 1'b0, tick_inc: 1'b0, scan_start: 1'b0,
      scan_step: 1'b0, commit: 1'b0, done: 1'b0, jump: JMP_NEXT, target: STEP_DONE};

   function automatic step_type entry_step(input logic [1:0] func);
      step_type s;
      unique case (func)
         FUNC_CREATE: s = STEP_CREATE;
         FUNC_DELAY:  s = STEP_DELAY;
         FUNC_TICK:   s = STEP_TICK;
         default:     s = STEP_SCAN_START;
      endcase
      return s;
   endfunction

   // control store: one word per step
   function automatic ctrl_type control_word(input step_type step);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (step)
         STEP_CREATE: begin
            w.wr_create = 1'b1;
            w.jump      = JMP_ALWAYS;
            w.target    = STEP_DONE;
         end
         STEP_DELAY: begin
            w.wr_delay = 1'b1;
            w.jump     = JMP_ALWAYS;
            w.target   = STEP_SCAN_START;
         end
         STEP_TICK: begin
            w.tick_inc = 1'b1;
            w.jump     = JMP_NEXT;
         end
         STEP_SCAN_START: begin
            w.scan_start = 1'b1;
            w.jump       = JMP_IF_EMPTY;
            w.target     = STEP_COMMIT;
         end
         STEP_SCAN: begin
            w.scan_step = 1'b1;
            w.jump      = JMP_IF_MORE;
            w.target    = STEP_SCAN;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.jump   = JMP_NEXT;
         end
         STEP_DONE: begin
            w.done   = 1'b1;
            w.jump   = JMP_ALWAYS;
            w.target = STEP_DONE;
         end
         default: w = CTRL_NOP;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/pts_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/pts_sequencer.sv */
// step counter and control store sequencer
`default_nettype none
module pts_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           func,
   input  wire pts_pkg::status_type  status,
   output logic                      busy,
   output pts_pkg::ctrl_type         ctrl
);

   pts_pkg::step_type step_ff, step_in;
   logic              busy_ff, busy_in;
   pts_pkg::ctrl_type word;

   assign word = pts_pkg::control_word(step_ff);

   always_comb begin
      pts_pkg::step_type seq_next;
      seq_next = pts_pkg::step_type'(step_ff + 3'd1);
      unique case (word.jump)
         pts_pkg::JMP_NEXT:     step_in = seq_next;
         pts_pkg::JMP_ALWAYS:   step_in = word.target;
         pts_pkg::JMP_IF_EMPTY: step_in = status.empty ? word.target : seq_next;
         pts_pkg::JMP_IF_MORE:  step_in = status.more ? word.target : seq_next;
         default:               step_in = seq_next;
      endcase
      busy_in = busy_ff;
      if (!busy_ff) begin
         step_in = pts_pkg::entry_step(func);
         busy_in = start;
      end else if (word.done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= pts_pkg::STEP_DONE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;
   assign ctrl = busy_ff ? word : pts_pkg::CTRL_NOP;

endmodule
`default_nettype wire

/* rtl/core/pts_datapath.sv */
// task table, scan datapath and result register
`default_nettype none
module pts_datapath #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire pts_pkg::req_type    req,
   input  wire pts_pkg::ctrl_type   ctrl,
   output pts_pkg::status_type      status,
   output logic                     rsp_valid,
   output pts_pkg::rsp_type         rsp
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   // item fields held for the whole event
   logic [1:0]                  func_ff;
   logic [pts_pkg::PRIO_W-1:0]  prio_ff;
   logic [pts_pkg::DELAY_W-1:0] amount_ff;

   logic [CNT_W-1:0]            used_ff, used_in;
   logic [IDX_W-1:0]            cur_ff, cur_in;
   logic                        present_ff, present_in;
   logic [pts_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic                        acc_ff, acc_in;
   logic [CNT_W-1:0]            eval_ff, eval_in;
   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            best_ff, best_in;
   logic [pts_pkg::PRIO_W-1:0]  lead_prio_ff, lead_prio_in;
   logic                        rsp_valid_ff;
   pts_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        full;
   logic [CNT_W-1:0]            eval_next;
   logic                        tick_event;

   logic                        st_wr_en;
   logic [IDX_W-1:0]            st_wr_addr;
   pts_pkg::slot_state_type     st_wr_data;
   pts_pkg::slot_state_type     st_rd_data;
   pts_pkg::slot_state_type     st_upd;
   logic                        pr_wr_en;
   logic [pts_pkg::PRIO_W-1:0]  pr_rd_data;
   logic [IDX_W-1:0]            rd_addr;

   assign full       = (used_ff == CNT_W'(TASK_SLOTS));
   assign eval_next  = eval_ff + CNT_W'(1);
   assign tick_event = (func_ff == pts_pkg::FUNC_TICK);

   assign status.empty = (used_ff == '0);
   assign status.more  = (eval_next < used_ff);

   // count down a blocked nonzero delay on a tick, release at zero
   always_comb begin
      st_upd = st_rd_data;
      if (tick_event && st_rd_data.blocked && (st_rd_data.delay != '0)) begin
         st_upd.delay   = st_rd_data.delay - pts_pkg::DELAY_W'(1);
         st_upd.blocked = (st_upd.delay != '0);
      end
   end

   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = eval_ff[IDX_W-1:0];
      st_wr_data = st_upd;
      if (ctrl.wr_create) begin
         st_wr_en   = !full;
         st_wr_addr = used_ff[IDX_W-1:0];
         st_wr_data = '{blocked: 1'b0, delay: '0};
      end else if (ctrl.wr_delay) begin
         st_wr_en   = present_ff;
         st_wr_addr = cur_ff;
         st_wr_data = '{blocked: 1'b1, delay: amount_ff};
      end else if (ctrl.scan_step) begin
         st_wr_en   = tick_event;
      end
   end

   assign pr_wr_en = ctrl.wr_create && !full;
   assign rd_addr  = ctrl.scan_start ? '0 : eval_next[IDX_W-1:0];

   pts_ram #(
      .WIDTH (pts_pkg::STATE_W),
      .DEPTH (TASK_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (rd_addr),
      .rd_data (st_rd_data)
   );

   pts_ram #(
      .WIDTH (pts_pkg::PRIO_W),
      .DEPTH (TASK_SLOTS)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (used_ff[IDX_W-1:0]),
      .wr_data (prio_ff),
      .rd_addr (rd_addr),
      .rd_data (pr_rd_data)
   );

   always_comb begin
      used_in      = used_ff;
      cur_in       = cur_ff;
      present_in   = present_ff;
      tick_in      = tick_ff;
      acc_in       = acc_ff;
      eval_in      = eval_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      lead_prio_in = lead_prio_ff;
      rsp_in       = rsp_ff;

      if (accept) begin
         acc_in = 1'b0;
      end
      if (ctrl.wr_create && !full) begin
         used_in = used_ff + CNT_W'(1);
         acc_in  = 1'b1;
      end
      if (ctrl.wr_delay && present_ff) begin
         acc_in = 1'b1;
      end
      if (ctrl.tick_inc) begin
         tick_in = tick_ff + pts_pkg::TICK_W'(1);
      end
      if (ctrl.scan_start) begin
         eval_in      = '0;
         found_in     = 1'b0;
         best_in      = '0;
         lead_prio_in = '0;
      end
      // ready task beats the best so far only on strictly higher priority
      if (ctrl.scan_step) begin
         eval_in = eval_next;
         if (!st_upd.blocked && (!found_ff || (pr_rd_data > lead_prio_ff))) begin
            found_in     = 1'b1;
            best_in      = eval_ff[IDX_W-1:0];
            lead_prio_in = pr_rd_data;
         end
      end
      if (ctrl.commit) begin
         present_in = found_ff;
         cur_in     = found_ff ? best_ff : '0;
      end
      if (ctrl.done) begin
         rsp_in.running_task  = present_ff ? pts_pkg::TASK_W'(cur_ff) : '0;
         rsp_in.running_valid = present_ff;
         rsp_in.accepted      = acc_ff;
         rsp_in.tick_total    = tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cur_ff       <= '0;
         present_ff   <= 1'b0;
         tick_ff      <= '0;
         acc_ff       <= 1'b0;
         eval_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cur_ff       <= cur_in;
         present_ff   <= present_in;
         tick_ff      <= tick_in;
         acc_ff       <= acc_in;
         eval_ff      <= eval_in;
         found_ff     <= found_in;
         rsp_valid_ff <= ctrl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req.func;
         prio_ff   <= req.new_priority;
         amount_ff <= req.delay_amount;
      end
      best_ff      <= best_in;
      lead_prio_ff <= lead_prio_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

/* rtl/core/priority_task_scheduler_with_delays_top.sv */
// top level of the fixed priority task scheduler with tick delays
`default_nettype none
// Usage: drive req_data and raise start; the item is taken at the rising edge
// where start is high and busy is low. busy stays high until the result is
// out. Events: create a task, delay the current task, tick, schedule.
// Each item yields exactly one result on rsp_data, marked by rsp_valid for a
// single cycle; the receiver cannot hold it off and must take it then.
// Create goes straight to the result; tick and delay do their update and then
// run a schedule scan. The control store steps the scan through one slot per
// cycle, reading the slot rams one entry ahead while, on a tick, it writes
// back the counted-down delay of the entry in hand.
// A new item can be taken in the cycle that the result is shown.
// Reset (synchronous, active high) empties the task table, clears the tick
// count and the current selection; the slot rams need no clearing since only
// created slots are ever used.
module priority_task_scheduler_with_delays_top #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pts_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pts_pkg::rsp_type      rsp_data
);

   pts_pkg::ctrl_type   ctrl;
   pts_pkg::status_type status;
   logic                accept;

   assign accept = start && !busy;

   pts_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_data.func),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   pts_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
`default_nettype wire
